// ===== rtl/fbvr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fbvr_pkg;

	localparam int DEF_BUFFER_DEPTH = 4096;
	localparam int DEF_WORD_WIDTH   = 64;

	localparam int ACTION_W    = 3;
	localparam int LOAD_ADDR_W = 12;
	localparam int DATA_W      = 8;
	localparam int COUNT_W     = 4;
	localparam int VALUE_W     = 64;
	localparam int STATUS_W    = 2;
	localparam int BLEN_W      = 13;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [ACTION_W-1:0] ACT_LOAD   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_REWIND = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_BITS   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_WORD   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_FILL   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DECODE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

	// Register index decoded from paddr[2].
	localparam logic REG_BUFFER_LENGTH = 1'b0;

	localparam logic [COUNT_W-1:0] GROUP_BITS   = 4'd8;
	localparam int                 GROUP_DATA_W = 7;

	typedef struct packed {
		logic                latch;
		logic                load_wr;
		logic                rewind;
		logic                init_walk;
		logic                fetch0;
		logic                fetch1;
		logic                step;
		logic                fin;
		logic [STATUS_W-1:0] fin_status;
		logic                commit;
		logic                out_load;
	} fbvr_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                count_zero;
		logic                count_big;
		logic                at_end;
		logic                span_fail;
		logic                group_bad;
		logic                more;
		logic                filler_hit;
	} fbvr_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fbvr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbvr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fbvr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbvr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire fbvr_pkg::fbvr_stat_t stat,
	output fbvr_pkg::fbvr_cmd_t      cmd
);

	import fbvr_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DISP   = 6'b000010,
		S_FETCH0 = 6'b000100,
		S_FETCH1 = 6'b001000,
		S_EXEC   = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.action) inside
					ACT_LOAD: begin
						cmd.load_wr    = 1'b1;
						cmd.fin        = 1'b1;
						cmd.fin_status = ST_OK;
						state_d        = S_FIN;
					end
					ACT_REWIND: begin
						cmd.rewind     = 1'b1;
						cmd.fin        = 1'b1;
						cmd.fin_status = ST_OK;
						state_d        = S_FIN;
					end
					ACT_BITS: begin
						if (stat.count_big) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = ST_INVALID;
							state_d        = S_FIN;
						end else if (stat.count_zero) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = ST_OK;
							state_d        = S_FIN;
						end else begin
							cmd.init_walk = 1'b1;
							state_d       = S_FETCH0;
						end
					end
					ACT_WORD, ACT_FILL: begin
						cmd.init_walk = 1'b1;
						state_d       = S_FETCH0;
					end
					default: begin
						cmd.fin        = 1'b1;
						cmd.fin_status = ST_INVALID;
						state_d        = S_FIN;
					end
				endcase
			end
			S_FETCH0: begin
				if (stat.at_end) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = ST_DECODE;
					state_d        = S_FIN;
				end else begin
					cmd.fetch0 = 1'b1;
					state_d    = S_FETCH1;
				end
			end
			S_FETCH1: begin
				cmd.fetch1 = 1'b1;
				state_d    = S_EXEC;
			end
			S_EXEC: begin
				unique case (stat.action)
					ACT_BITS: begin
						cmd.fin = 1'b1;
						state_d = S_FIN;
						if (stat.span_fail) begin
							cmd.fin_status = ST_DECODE;
						end else begin
							cmd.step       = 1'b1;
							cmd.fin_status = ST_OK;
						end
					end
					ACT_WORD: begin
						if (stat.span_fail || stat.group_bad) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = ST_DECODE;
							state_d        = S_FIN;
						end else begin
							cmd.step = 1'b1;
							if (stat.more) begin
								state_d = S_FETCH0;
							end else begin
								cmd.fin        = 1'b1;
								cmd.fin_status = ST_OK;
								state_d        = S_FIN;
							end
						end
					end
					ACT_FILL: begin
						cmd.step = 1'b1;
						if (stat.filler_hit) begin
							cmd.fin        = 1'b1;
							cmd.fin_status = ST_OK;
							state_d        = S_FIN;
						end else begin
							state_d = S_FETCH0;
						end
					end
					default: begin
						cmd.fin        = 1'b1;
						cmd.fin_status = ST_INVALID;
						state_d        = S_FIN;
					end
				endcase
			end
			S_FIN: begin
				// The cursor commit is idempotent, so it may repeat while the output is full.
				cmd.commit = 1'b1;
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fbvr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbvr_datapath #(
	parameter int BUFFER_DEPTH = fbvr_pkg::DEF_BUFFER_DEPTH,
	parameter int WORD_WIDTH   = fbvr_pkg::DEF_WORD_WIDTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire fbvr_pkg::fbvr_cmd_t               cmd,
	output fbvr_pkg::fbvr_stat_t                   stat,
	input  wire logic [fbvr_pkg::BLEN_W-1:0]       buffer_length,
	input  wire logic [fbvr_pkg::ACTION_W-1:0]     action,
	input  wire logic [fbvr_pkg::LOAD_ADDR_W-1:0]  load_address,
	input  wire logic [fbvr_pkg::DATA_W-1:0]       load_data,
	input  wire logic [fbvr_pkg::COUNT_W-1:0]      bit_count,
	output logic      [fbvr_pkg::VALUE_W-1:0]      value,
	output logic      [fbvr_pkg::STATUS_W-1:0]     status
);

	import fbvr_pkg::*;

	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int CUR_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int CMP_W  = ((CUR_W > BLEN_W) ? CUR_W : BLEN_W) + 1;
	localparam int SH_W   = $clog2(WORD_WIDTH + GROUP_DATA_W);
	localparam int EXT_W  = WORD_WIDTH + GROUP_DATA_W;

	function automatic logic [2:0] first_one(input logic [DATA_W-1:0] m);
		logic [2:0] p;
		p = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (m[i]) begin
				p = 3'(DATA_W - 1 - i);
			end
		end
		return p;
	endfunction

	logic [ACTION_W-1:0]    action_q;
	logic [LOAD_ADDR_W-1:0] load_address_q;
	logic [DATA_W-1:0]      load_data_q;
	logic [COUNT_W-1:0]     count_q;
	logic [CUR_W-1:0]       byte_cur_q;
	logic [2:0]             bit_cur_q;
	logic [CUR_W-1:0]       wbyte_q;
	logic [2:0]             wbit_q;
	logic [DATA_W-1:0]      byte0_q;
	logic [WORD_WIDTH-1:0]  acc_q;
	logic [SH_W-1:0]        shift_q;
	logic                   walk_q;
	logic [STATUS_W-1:0]    res_status_q;

	logic [DATA_W-1:0]      rdata;
	logic [CUR_W-1:0]       wbyte_p1;
	logic [CMP_W-1:0]       eff_len;
	logic [CMP_W-1:0]       blen_x;
	logic [CMP_W-1:0]       depth_x;
	logic [CMP_W-1:0]       wbyte_x;
	logic [COUNT_W-1:0]     k;
	logic [COUNT_W-1:0]     sum;
	logic [15:0]            win;
	logic [DATA_W-1:0]      bits;
	logic [DATA_W-1:0]      masked;
	logic [2:0]             pos;
	logic [COUNT_W-1:0]     fsum;
	logic [EXT_W-1:0]       ext;
	logic                   full;
	logic                   addr_ok;
	logic [CUR_W-1:0]       next_byte;
	logic [2:0]             next_bit;

	assign wbyte_p1 = wbyte_q + 1'b1;
	assign blen_x   = CMP_W'(buffer_length);
	assign depth_x  = CMP_W'(BUFFER_DEPTH);
	assign eff_len  = (blen_x < depth_x) ? blen_x : depth_x;
	assign wbyte_x  = CMP_W'(wbyte_q);
	assign addr_ok  = (32'(load_address_q) < 32'(BUFFER_DEPTH));

	// A bit read and a varint group share one window over two adjacent bytes.
	assign k    = (action_q == ACT_WORD) ? GROUP_BITS : count_q;
	assign sum  = {1'b0, wbit_q} + k;
	assign win  = {byte0_q, rdata} << wbit_q;
	assign bits = win[15:8] >> (GROUP_BITS - k);

	assign masked = byte0_q << wbit_q;
	assign pos    = first_one(masked);
	assign fsum   = {1'b0, wbit_q} + {1'b0, pos} + 4'd1;

	assign full = (shift_q >= SH_W'(WORD_WIDTH));
	assign ext  = EXT_W'(bits[GROUP_DATA_W-1:0]) << shift_q;

	assign stat.action     = action_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.count_big  = (count_q > GROUP_BITS);
	assign stat.at_end     = (wbyte_x >= eff_len);
	assign stat.span_fail  = (sum > GROUP_BITS) && ((wbyte_x + 1'b1) >= eff_len);
	assign stat.group_bad  = full ? (bits[GROUP_DATA_W-1:0] != '0)
	                              : (ext[EXT_W-1:WORD_WIDTH] != '0);
	assign stat.more       = bits[DATA_W-1];
	assign stat.filler_hit = (masked != '0);

	always_comb begin
		if (action_q == ACT_FILL) begin
			if (masked != '0) begin
				next_byte = fsum[3] ? wbyte_p1 : wbyte_q;
				next_bit  = fsum[2:0];
			end else begin
				next_byte = wbyte_p1;
				next_bit  = '0;
			end
		end else begin
			next_byte = sum[3] ? wbyte_p1 : wbyte_q;
			next_bit  = sum[2:0];
		end
	end

	fbvr_ram #(
		.WIDTH(DATA_W),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.load_wr && addr_ok),
		.waddr (ADDR_W'(load_address_q)),
		.wdata (load_data_q),
		.re    (cmd.fetch0 || cmd.fetch1),
		.raddr (cmd.fetch0 ? wbyte_q[ADDR_W-1:0] : wbyte_p1[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cur_q <= '0;
			bit_cur_q  <= '0;
			walk_q     <= 1'b0;
		end else begin
			if (cmd.latch) begin
				walk_q <= 1'b0;
			end else if (cmd.init_walk) begin
				walk_q <= 1'b1;
			end
			if (cmd.rewind) begin
				byte_cur_q <= '0;
				bit_cur_q  <= '0;
			end else if (cmd.commit && walk_q && res_status_q == ST_OK) begin
				byte_cur_q <= wbyte_q;
				bit_cur_q  <= wbit_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q       <= action;
			load_address_q <= load_address;
			load_data_q    <= load_data;
			count_q        <= bit_count;
			acc_q          <= '0;
		end
		if (cmd.init_walk) begin
			wbyte_q <= byte_cur_q;
			wbit_q  <= bit_cur_q;
			shift_q <= '0;
		end
		if (cmd.fetch1) begin
			byte0_q <= rdata;
		end
		if (cmd.step) begin
			wbyte_q <= next_byte;
			wbit_q  <= next_bit;
			if (action_q == ACT_BITS) begin
				acc_q <= WORD_WIDTH'(bits);
			end else if (action_q == ACT_WORD && !full) begin
				acc_q   <= acc_q | ext[WORD_WIDTH-1:0];
				shift_q <= shift_q + SH_W'(GROUP_DATA_W);
			end
		end
		if (cmd.fin) begin
			res_status_q <= cmd.fin_status;
		end
		if (cmd.out_load) begin
			value  <= (res_status_q == ST_OK) ? VALUE_W'(acc_q) : '0;
			status <= res_status_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/flat_bitstream_varint_reader.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// config    psel/penable/pready    pwrite, paddr, pwdata, prdata (buffer_length at 0x0)
// request   in_valid/in_ready      action, load_address, load_data, bit_count
// result    out_valid/out_ready    value, status
//
// For a load, rewind or rejected request, dispatch goes straight to the finish state.
// A bit read, each varint group and each filler byte scanned pass through the fetch0, fetch1
// and exec states, set by the two reads of the registered byte memory per step.
// in_ready returns with out_valid; a full result register holds the block until out_ready.
// Reset clears the cursor, the length register and the handshake state; the byte
// memory holds no reset value and has no clearing pass.
// A new request is taken while an earlier result waits for out_ready.

module flat_bitstream_varint_reader #(
	parameter int BUFFER_DEPTH = fbvr_pkg::DEF_BUFFER_DEPTH,
	parameter int WORD_WIDTH   = fbvr_pkg::DEF_WORD_WIDTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [fbvr_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [fbvr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [fbvr_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [fbvr_pkg::ACTION_W-1:0]     action,
	input  wire logic [fbvr_pkg::LOAD_ADDR_W-1:0]  load_address,
	input  wire logic [fbvr_pkg::DATA_W-1:0]       load_data,
	input  wire logic [fbvr_pkg::COUNT_W-1:0]      bit_count,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [fbvr_pkg::VALUE_W-1:0]      value,
	output logic      [fbvr_pkg::STATUS_W-1:0]     status
);

	import fbvr_pkg::*;

	logic [BLEN_W-1:0] buffer_length_q;
	logic              reg_hit;
	fbvr_cmd_t         cmd;
	fbvr_stat_t        stat;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_BUFFER_LENGTH);
	assign prdata  = reg_hit ? APB_DATA_W'(buffer_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			buffer_length_q <= pwdata[BLEN_W-1:0];
		end
	end

	fbvr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbvr_datapath #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.WORD_WIDTH  (WORD_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.buffer_length (buffer_length_q),
		.action        (action),
		.load_address  (load_address),
		.load_data     (load_data),
		.bit_count     (bit_count),
		.value         (value),
		.status        (status)
	);

endmodule

`default_nettype wire

// ===== rtl/fbvr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbvr_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [fbvr_pkg::VALUE_W-1:0]  value,
	input wire logic [fbvr_pkg::STATUS_W-1:0] status
);

	import fbvr_pkg::*;

	// Every request passes through the dispatch state, so the block is busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken on two consecutive cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_DECODE || status == ST_INVALID))
		else $error("result carries an undefined status");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> value == '0)
		else $error("failed request returned a nonzero value");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
		else $error("stalled result changed or dropped");

endmodule

bind flat_bitstream_varint_reader fbvr_checker u_fbvr_checker (.*);

`default_nettype wire
